// ----- hdl/scafu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scafu_pkg: shared types and constants of the current abnormality flag unit
// Register map, reset values, step limits and the configuration bundle.
// ----------------------------------------------------------------------------
package scafu_pkg;

    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 16;
    localparam int CFG_W    = 16;
    localparam int ADDR_W   = 3;

    // register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_WARMUP_INDEX      = 3'd0;
    localparam logic [ADDR_W-1:0] REG_TRACK_START_INDEX = 3'd1;
    localparam logic [ADDR_W-1:0] REG_HIGH_LIMIT        = 3'd2;
    localparam logic [ADDR_W-1:0] REG_LOW_START_LIMIT   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_RECOVERY_LEVEL    = 3'd4;
    localparam logic [ADDR_W-1:0] REG_JUMP_THRESHOLD    = 3'd5;

    localparam logic [CFG_W-1:0] RST_WARMUP_INDEX      = 16'd60;
    localparam logic [CFG_W-1:0] RST_TRACK_START_INDEX = 16'd15;
    localparam logic [CFG_W-1:0] RST_HIGH_LIMIT        = 16'd17920;
    localparam logic [CFG_W-1:0] RST_LOW_START_LIMIT   = 16'd384;
    localparam logic [CFG_W-1:0] RST_RECOVERY_LEVEL    = 16'd256;
    localparam logic [CFG_W-1:0] RST_JUMP_THRESHOLD    = 16'd512;

    // Variance is d*d/4 in Q16.16. The fixed variance limits reduce to
    // limits on |d| itself:
    //   d*d > 524    <=> d >= 23  (noisy step)
    //   d*d < 262144 <=> d < 512  (quiet), d*d > 262144 <=> d > 512 (loud)
    localparam logic [SAMPLE_W-1:0] NOISY_STEP_MIN = 16'd23;
    localparam logic [SAMPLE_W-1:0] UNIT_STEP      = 16'd512;
    localparam logic [INDEX_W-1:0]  JUMP_MIN_INDEX = 16'd2;
    localparam logic [1:0]          NOISY_RUN_MAX  = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] warmup_index;
        logic [CFG_W-1:0] track_start_index;
        logic [CFG_W-1:0] high_limit;
        logic [CFG_W-1:0] low_start_limit;
        logic [CFG_W-1:0] recovery_level;
        logic [CFG_W-1:0] jump_threshold;
    } cfg_t;

endpackage
`default_nettype wire

// ----- hdl/sensor_current_abnormality_flag_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_current_abnormality_flag_unit: current abnormality flag, top level
// Input register, decision core, result register and configuration file.
// ----------------------------------------------------------------------------
//  channel   ports        tdata / data bits
//  input     s_axis_*     [15:0] sample, [31:16] sample_index
//  result    m_axis_*     [0] abnormal, [7:1] zero
//  config    cfg_*        cfg_addr selects register, cfg_wdata 16 bits
//
//  One transaction per cycle sustained while the result side is ready. A
//  sample passes through the input register, then the result register,
//  before its result transaction is offered.
//  The state update happens as a sample moves into the result register.
//  A stalled result holds; the input register still takes one transaction.
//  aresetn is synchronous; it clears state and restores register defaults.
// ----------------------------------------------------------------------------
module sensor_current_abnormality_flag_unit
    import scafu_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,

    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire  [31:0]       s_axis_tdata,   // [15:0] sample, [31:16] sample_index

    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] abnormal, [7:1] zero

    input  wire               cfg_we,
    input  wire  [ADDR_W-1:0] cfg_addr,
    input  wire  [CFG_W-1:0]  cfg_wdata
);

    cfg_t cfg;

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic                out_valid_reg;
    logic                abnormal_reg;
    logic                flag;
    logic                advance;
    logic                take_in;

    scafu_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    scafu_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .commit       (advance),
        .sample       (sample_reg),
        .sample_index (index_reg),
        .flag         (flag)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            sample_reg <= s_axis_tdata[15:0];
            index_reg  <= s_axis_tdata[31:16];
        end
        if (advance) begin
            abnormal_reg <= flag;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, abnormal_reg};

endmodule
`default_nettype wire

// ----- hdl/scafu_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scafu_regs: configuration register file
// Six 16-bit write-only registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module scafu_regs
    import scafu_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_we,
    input  wire  [ADDR_W-1:0] cfg_addr,
    input  wire  [CFG_W-1:0]  cfg_wdata,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_WARMUP_INDEX:      cfg_next.warmup_index      = cfg_wdata;
                REG_TRACK_START_INDEX: cfg_next.track_start_index = cfg_wdata;
                REG_HIGH_LIMIT:        cfg_next.high_limit        = cfg_wdata;
                REG_LOW_START_LIMIT:   cfg_next.low_start_limit   = cfg_wdata;
                REG_RECOVERY_LEVEL:    cfg_next.recovery_level    = cfg_wdata;
                REG_JUMP_THRESHOLD:    cfg_next.jump_threshold    = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warmup_index      <= RST_WARMUP_INDEX;
            cfg_reg.track_start_index <= RST_TRACK_START_INDEX;
            cfg_reg.high_limit        <= RST_HIGH_LIMIT;
            cfg_reg.low_start_limit   <= RST_LOW_START_LIMIT;
            cfg_reg.recovery_level    <= RST_RECOVERY_LEVEL;
            cfg_reg.jump_threshold    <= RST_JUMP_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- hdl/scafu_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scafu_core: decision logic and tracking state
// Evaluates one registered sample against the kept state and commits the
// new state when the sample moves on to the result register.
// ----------------------------------------------------------------------------
module scafu_core
    import scafu_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  cfg_t                cfg,
    input  wire                 commit,
    input  wire  [SAMPLE_W-1:0] sample,
    input  wire  [INDEX_W-1:0]  sample_index,
    output logic                flag
);

    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic                abn_reg, abn_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] max_reg, max_next;

    logic [SAMPLE_W-1:0] step;
    logic                recovered;
    logic                cleared;
    logic                set_jump;
    logic                set_low;
    logic                set_rise;
    logic                set_high;

    always_comb begin
        step = (sample >= prev_reg) ? (sample - prev_reg) : (prev_reg - sample);

        recovered = abn_reg && ((sample <= cfg.recovery_level) ||
                    ((step < UNIT_STEP) && (cnt_reg == NOISY_RUN_MAX)));
        cleared   = abn_reg && !recovered;

        set_jump = (step > cfg.jump_threshold) && (step > UNIT_STEP) && !cleared &&
                   (sample_index > JUMP_MIN_INDEX);
        set_low  = (sample < cfg.low_start_limit) && (sample_index < cfg.warmup_index);
        set_rise = abn_reg && (sample > max_reg) && (sample_index > cfg.track_start_index) &&
                   (max_reg != '0);
        set_high = (sample_index < cfg.warmup_index) && (sample > cfg.high_limit);

        flag = cleared || set_jump || set_low || set_rise || set_high;

        if (step >= NOISY_STEP_MIN) begin
            cnt_next = (cnt_reg == NOISY_RUN_MAX) ? cnt_reg : cnt_reg + 2'd1;
        end else begin
            cnt_next = '0;
        end

        // maximum only follows while the block stays normal
        if ((prev_reg > max_reg) && !flag && (sample_index > cfg.track_start_index)) begin
            max_next = prev_reg;
        end else begin
            max_next = max_reg;
        end

        prev_next = sample;
        abn_next  = flag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            abn_reg  <= 1'b0;
            cnt_reg  <= '0;
            max_reg  <= '0;
        end else if (commit) begin
            prev_reg <= prev_next;
            abn_reg  <= abn_next;
            cnt_reg  <= cnt_next;
            max_reg  <= max_next;
        end
    end

endmodule
`default_nettype wire

// ----- tb/sensor_current_abnormality_flag_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_current_abnormality_flag_unit_tb: self-checking bench for the unit
// Streams current samples through the unit under several limit settings and
// idling patterns. Each accepted sample runs through a local flag predictor,
// and each result is checked in order against the predicted abnormal flag.
// ----------------------------------------------------------------------------
module sensor_current_abnormality_flag_unit_tb;
    import scafu_pkg::*;

    // square-of-step limits for the fixed variance thresholds (var = d*d/4)
    localparam logic [31:0] NOISY_SQ = 32'd524;
    localparam logic [31:0] UNIT_SQ  = 32'd262144;

    // addresses past the register file; writes there must be ignored
    localparam logic [ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int DRAIN_CYCLES = 6;
    localparam int QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic [INDEX_W-1:0]  sample_index;
        logic [SAMPLE_W-1:0] sample;       // lowest bits of tdata
    } current_sample_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    wire               s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;   // [15:0] sample, [31:16] sample_index
    wire               m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    wire  [7:0]        m_axis_tdata;        // [0] abnormal, [7:1] zero
    logic              cfg_we = 1'b0;
    logic [ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    sensor_current_abnormality_flag_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    current_sample_t pending_samples[$];
    logic            expected_flags[$];
    current_sample_t sample_on_bus;
    int              src_idle_pct = 0;
    int              sink_stall_pct = 0;
    int              error_count = 0;
    int              quiet_cycles = 0;

    // predictor state and its copy of the limit registers
    cfg_t                limits;
    logic [SAMPLE_W-1:0] last_sample = '0;
    logic                abnormal_now = 1'b0;
    logic [1:0]          noisy_runs = '0;
    logic [SAMPLE_W-1:0] peak_sample = '0;

    // random walk that mimics a sensor session
    int                 walk_level = 1000;
    logic [INDEX_W-1:0] walk_index = '0;

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        error_count++;
        $display("[%0t] mismatch: %s (got %02h, expected %02h)", $time, what, got, want);
    endtask

    function automatic logic next_abnormal_flag(current_sample_t it);
        logic [SAMPLE_W-1:0] step;
        logic [31:0]         step_w;
        logic [31:0]         step_sq;
        logic                was_abnormal;
        logic                flag;
        step = (it.sample >= last_sample) ? it.sample - last_sample
                                          : last_sample - it.sample;
        step_w = step;
        step_sq = step_w * step_w;
        was_abnormal = abnormal_now;
        flag = abnormal_now;

        // recovery: low current, or a quiet step after a full noisy run
        if (flag && it.sample <= limits.recovery_level)
            flag = 1'b0;
        if (flag && step_sq < UNIT_SQ && noisy_runs == NOISY_RUN_MAX)
            flag = 1'b0;

        if (step_sq > NOISY_SQ) begin
            if (noisy_runs != NOISY_RUN_MAX)
                noisy_runs = noisy_runs + 2'd1;
        end else begin
            noisy_runs = '0;
        end

        if (step > limits.jump_threshold && step_sq > UNIT_SQ && !flag &&
            it.sample_index > JUMP_MIN_INDEX)
            flag = 1'b1;
        else if (it.sample < limits.low_start_limit &&
                 it.sample_index < limits.warmup_index)
            flag = 1'b1;
        else if (was_abnormal && it.sample > peak_sample &&
                 it.sample_index > limits.track_start_index && peak_sample != '0)
            flag = 1'b1;

        if (it.sample_index < limits.warmup_index && it.sample > limits.high_limit)
            flag = 1'b1;

        // the peak follows the previous sample only while normal
        if (last_sample > peak_sample && !flag &&
            it.sample_index > limits.track_start_index)
            peak_sample = last_sample;

        last_sample = it.sample;
        abnormal_now = flag;
        return flag;
    endfunction

    // sample source
    always @(posedge aclk) begin : drive_samples
        logic            fire;
        current_sample_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            fire = s_axis_tvalid && s_axis_tready;
            if (fire)
                expected_flags.push_back(next_abnormal_flag(sample_on_bus));
            if (!s_axis_tvalid || fire) begin
                if (pending_samples.size() != 0 &&
                    $urandom_range(99) >= src_idle_pct) begin
                    nxt = pending_samples.pop_front();
                    sample_on_bus = nxt;
                    s_axis_tdata  <= nxt;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge aclk) begin : check_flags
        logic want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_flags.size() == 0) begin
                    report_mismatch("result with no sample outstanding", m_axis_tdata, 8'h00);
                end else begin
                    want = expected_flags.pop_front();
                    if (m_axis_tdata !== {7'b0, want})
                        report_mismatch("abnormal flag", m_axis_tdata, {7'b0, want});
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
    endtask

    task automatic program_limits(cfg_t c);
        write_reg(REG_WARMUP_INDEX,      c.warmup_index);
        write_reg(REG_SPARE_LO,          16'($urandom));
        write_reg(REG_TRACK_START_INDEX, c.track_start_index);
        write_reg(REG_HIGH_LIMIT,        c.high_limit);
        write_reg(REG_LOW_START_LIMIT,   c.low_start_limit);
        write_reg(REG_RECOVERY_LEVEL,    c.recovery_level);
        write_reg(REG_JUMP_THRESHOLD,    c.jump_threshold);
        write_reg(REG_SPARE_HI,          16'($urandom));
        @(posedge aclk);
        cfg_we <= 1'b0;
        limits = c;
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_flags.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_sample(int level, logic [INDEX_W-1:0] idx);
        current_sample_t it;
        it.sample = level[SAMPLE_W-1:0];
        it.sample_index = idx;
        pending_samples.push_back(it);
    endtask

    task automatic push_random_session(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 3) begin
                // fresh sensor session: index restarts, warm-up applies again
                walk_index = '0;
                walk_level = $urandom_range(20000, 300);
            end
            r = $urandom_range(99);
            if (r < 68)
                walk_level = walk_level + int'($urandom_range(60)) - 30;
            else if (r < 76)
                walk_level = walk_level + int'($urandom_range(8)) - 4;
            else if (r < 86)
                walk_level = ($urandom_range(1)) ? walk_level + int'($urandom_range(4000, 513))
                                                 : walk_level - int'($urandom_range(4000, 513));
            else if (r < 92)
                walk_level = $urandom_range(400);
            else if (r < 96)
                walk_level = $urandom_range(19000, 17000);
            else
                walk_level = $urandom_range(65535);
            if (walk_level < 0)
                walk_level = 0;
            if (walk_level > 65535)
                walk_level = 65535;
            if ($urandom_range(99) < 95)
                walk_index = walk_index + 16'd1;
            else
                walk_index = 16'($urandom);
            push_sample(walk_level, walk_index);
        end
    endtask

    initial begin
        cfg_t c;
        limits = '{RST_WARMUP_INDEX, RST_TRACK_START_INDEX, RST_HIGH_LIMIT,
                   RST_LOW_START_LIMIT, RST_RECOVERY_LEVEL, RST_JUMP_THRESHOLD};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset limits, no idling
        push_sample(1000, 16'd0);       // first step measured from zero
        push_sample(1000, 16'd1);
        push_sample(2000, 16'd2);       // jump too early in the index
        push_sample(3000, 16'd3);       // jump taken
        push_sample(3030, 16'd4);       // noisy run builds up
        push_sample(3060, 16'd5);
        push_sample(3090, 16'd6);
        push_sample(3100, 16'd7);       // quiet step after saturated run
        push_sample(200,  16'd8);       // low during warm-up
        push_sample(100,  16'd9);       // below recovery level
        push_sample(65535, 16'd10);     // high during warm-up
        push_sample(0,    16'd65535);
        push_sample(1000, 16'd20);
        push_sample(1010, 16'd21);
        push_sample(1020, 16'd22);      // peak tracks while normal
        push_sample(1030, 16'd23);
        push_sample(3000, 16'd24);      // jump, now abnormal
        push_sample(3040, 16'd25);      // rise past peak while abnormal
        push_sample(3010, 16'd26);
        push_sample(65535, 16'd65535);
        push_sample(65535, 16'd0);
        push_sample(0,    16'd0);
        push_sample(256,  16'd61);
        push_sample(257,  16'd62);
        push_random_session(300);
        wait_drained();

        // all limits at zero, sender idling
        src_idle_pct = 74;
        program_limits('0);
        walk_index = '0;
        push_random_session(200);
        wait_drained();

        // all limits at full scale, receiver stalling
        src_idle_pct = 0;
        sink_stall_pct = 74;
        program_limits('1);
        walk_index = '0;
        push_random_session(200);
        wait_drained();

        // mid-range limits, light idling on both sides
        src_idle_pct = 12;
        sink_stall_pct = 12;
        c.warmup_index      = 16'd200;
        c.track_start_index = 16'd5;
        c.high_limit        = 16'd30000;
        c.low_start_limit   = 16'd1000;
        c.recovery_level    = 16'd600;
        c.jump_threshold    = 16'd100;
        program_limits(c);
        walk_index = '0;
        push_random_session(350);
        wait_drained();

        // back to power-on limits, full rate
        src_idle_pct = 0;
        sink_stall_pct = 0;
        program_limits('{RST_WARMUP_INDEX, RST_TRACK_START_INDEX, RST_HIGH_LIMIT,
                         RST_LOW_START_LIMIT, RST_RECOVERY_LEVEL, RST_JUMP_THRESHOLD});
        walk_index = '0;
        push_random_session(380);
        wait_drained();

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/scafu_pkg.sv
hdl/scafu_regs.sv
hdl/scafu_core.sv
hdl/sensor_current_abnormality_flag_unit.sv
tb/sensor_current_abnormality_flag_unit_tb.sv
